FILE: sv/hbkt_pkg.sv
`default_nettype none

package hbkt_pkg;

  // Report geometry
  localparam int unsigned REPORT_SLOTS  = 6;
  localparam int unsigned KEY_SLOTS_DEF = 6;
  localparam int unsigned SET_DEPTH     = 3;

  // Usage codes and modifier masks
  localparam logic [7:0] USAGE_NONE = 8'h00;
  localparam logic [7:0] USAGE_CAPS = 8'h39;
  localparam logic [4:0] MOD_PREFIX = 5'b11100;     // 0xE0..0xE7
  localparam logic [7:0] SHIFT_MASK = 8'h22;        // left and right shift bits
  localparam logic [7:0] HOLD_MAX   = 8'hFF;
  localparam logic [7:0] HOLD_ONE   = 8'h01;

  // Report counts per event
  localparam logic [1:0] CNT_NORMAL = 2'd1;
  localparam logic [1:0] CNT_CAPS   = 2'd3;

  typedef struct packed {
    logic       pressed;
    logic [7:0] keycode;
    logic       caps_pair;
  } event_t;

  typedef struct packed {
    logic [7:0]                   modifiers;
    logic [REPORT_SLOTS-1:0][7:0] slots;
    logic                         last;
  } report_t;

  // Reports produced by one event, in emit order
  typedef struct packed {
    logic [1:0]                count;
    report_t [SET_DEPTH-1:0]   rep;
  } rpt_set_t;

  // Report buffer status seen by the event stage
  typedef struct packed {
    logic can_load;
    logic busy;
  } buf_stat_t;

endpackage

`default_nettype wire

FILE: sv/hbkt_event_if.sv
`default_nettype none

interface hbkt_event_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic [7:0] keycode;
  logic       caps_pair;

  modport source (output valid, output pressed, output keycode, output caps_pair,
                  input ready);
  modport sink (input valid, input pressed, input keycode, input caps_pair,
                output ready);
endinterface

`default_nettype wire

FILE: sv/hbkt_report_if.sv
`default_nettype none

interface hbkt_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] slot0;
  logic [7:0] slot1;
  logic [7:0] slot2;
  logic [7:0] slot3;
  logic [7:0] slot4;
  logic [7:0] slot5;
  logic       last;

  modport source (output valid, output modifiers, output slot0, output slot1,
                  output slot2, output slot3, output slot4, output slot5,
                  output last, input ready);
  modport sink (input valid, input modifiers, input slot0, input slot1,
                input slot2, input slot3, input slot4, input slot5,
                input last, output ready);
endinterface

`default_nettype wire

FILE: sv/hbkt_update.sv
`default_nettype none

module hbkt_update #(
  parameter int unsigned KeySlots = hbkt_pkg::KEY_SLOTS_DEF
) (
  input  hbkt_pkg::event_t           ev_i,
  input  logic [7:0]                 mods_i,
  input  logic [KeySlots-1:0][7:0]   slots_i,
  input  logic [7:0]                 hold_i,
  output logic [7:0]                 mods_o,
  output logic [KeySlots-1:0][7:0]   slots_o,
  output logic [7:0]                 hold_o,
  output hbkt_pkg::rpt_set_t         set_o
);

  typedef logic [KeySlots-1:0][7:0] slots_t;

  // Lowest empty slot takes the code; full table drops it
  function automatic slots_t slot_put(slots_t s, logic [7:0] code);
    slots_t r;
    logic   done;
    r    = s;
    done = 1'b0;
    for (int i = 0; i < KeySlots; i++) begin
      if (!done && r[i] == hbkt_pkg::USAGE_NONE) begin
        r[i] = code;
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // Lowest slot holding the code is cleared
  function automatic slots_t slot_drop(slots_t s, logic [7:0] code);
    slots_t r;
    logic   done;
    r    = s;
    done = 1'b0;
    for (int i = 0; i < KeySlots; i++) begin
      if (!done && r[i] == code) begin
        r[i] = hbkt_pkg::USAGE_NONE;
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // Only the first six slots reach a report
  function automatic logic [hbkt_pkg::REPORT_SLOTS-1:0][7:0] slot_view(slots_t s);
    logic [hbkt_pkg::REPORT_SLOTS-1:0][7:0] v;
    for (int j = 0; j < hbkt_pkg::REPORT_SLOTS; j++) begin
      v[j] = (j < KeySlots) ? s[j] : hbkt_pkg::USAGE_NONE;
    end
    return v;
  endfunction

  logic       is_mod;
  logic       seq;
  logic [7:0] hold_dec;
  logic [7:0] mods_a;
  logic [7:0] mods_b;
  slots_t     slots_a;
  slots_t     slots_b;
  slots_t     slots_c;

  assign is_mod = (ev_i.keycode[7:3] == hbkt_pkg::MOD_PREFIX);

  // Hold count release step, floored at zero
  assign hold_dec = (ev_i.caps_pair && !ev_i.pressed && hold_i != 8'd0)
                  ? hold_i - 8'd1 : hold_i;

  // Apply the event key
  always_comb begin
    mods_a  = mods_i;
    slots_a = slots_i;
    if (ev_i.keycode != hbkt_pkg::USAGE_NONE) begin
      if (is_mod) begin
        mods_a[ev_i.keycode[2:0]] = ev_i.pressed;
      end else if (ev_i.pressed) begin
        slots_a = slot_put(slots_i, ev_i.keycode);
      end else begin
        slots_a = slot_drop(slots_i, ev_i.keycode);
      end
    end
  end

  // Caps-lock tap: shifts lifted, caps pressed then released
  assign seq     = ev_i.caps_pair && ev_i.pressed && (hold_dec == hbkt_pkg::HOLD_ONE);
  assign mods_b  = mods_a & ~hbkt_pkg::SHIFT_MASK;
  assign slots_b = slot_put(slots_a, hbkt_pkg::USAGE_CAPS);
  assign slots_c = slot_drop(slots_b, hbkt_pkg::USAGE_CAPS);

  // Next state
  assign mods_o  = mods_a;
  assign slots_o = seq ? slots_c : slots_a;
  assign hold_o  = (ev_i.caps_pair && ev_i.pressed && hold_dec != hbkt_pkg::HOLD_MAX)
                 ? hold_dec + 8'd1 : hold_dec;

  // Reports in emit order
  always_comb begin
    set_o.count            = seq ? hbkt_pkg::CNT_CAPS : hbkt_pkg::CNT_NORMAL;
    set_o.rep[0].modifiers = seq ? mods_b : mods_a;
    set_o.rep[0].slots     = slot_view(seq ? slots_b : slots_a);
    set_o.rep[0].last      = !seq;
    set_o.rep[1].modifiers = mods_b;
    set_o.rep[1].slots     = slot_view(slots_c);
    set_o.rep[1].last      = 1'b0;
    set_o.rep[2].modifiers = mods_a;
    set_o.rep[2].slots     = slot_view(slots_c);
    set_o.rep[2].last      = 1'b1;
  end

endmodule

`default_nettype wire

FILE: sv/hbkt_report_buf.sv
`default_nettype none

module hbkt_report_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  hbkt_pkg::rpt_set_t    set_i,
  output hbkt_pkg::buf_stat_t   stat_o,
  hbkt_report_if.source         rpt_o
);

  hbkt_pkg::report_t [hbkt_pkg::SET_DEPTH-1:0] rep_q;
  hbkt_pkg::report_t                           cur;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;
  logic       pop;

  assign pop = rpt_o.valid && rpt_o.ready;

  // Room for a new set once the last pending report leaves
  assign stat_o.can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign stat_o.busy     = (cnt_q != 2'd0);

  // Pointer and fill count
  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = set_i.count;
      rd_d  = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  // Report storage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rep_q <= set_i.rep;
    end
  end

  // Current report
  always_comb begin
    case (rd_q)
      2'd0:    cur = rep_q[0];
      2'd1:    cur = rep_q[1];
      2'd2:    cur = rep_q[2];
      default: cur = rep_q[0];
    endcase
  end

  assign rpt_o.valid     = (cnt_q != 2'd0);
  assign rpt_o.modifiers = cur.modifiers;
  assign rpt_o.slot0     = cur.slots[0];
  assign rpt_o.slot1     = cur.slots[1];
  assign rpt_o.slot2     = cur.slots[2];
  assign rpt_o.slot3     = cur.slots[3];
  assign rpt_o.slot4     = cur.slots[4];
  assign rpt_o.slot5     = cur.slots[5];
  assign rpt_o.last      = cur.last;

endmodule

`default_nettype wire

FILE: sv/hid_boot_report_key_tracker.sv
`default_nettype none

// Channel  | Dir | Handshake   | Item
// ---------+-----+-------------+------------------------------------------
// evt_i    | in  | valid/ready | pressed, keycode, caps_pair
// rpt_o    | out | valid/ready | modifiers, slot0..slot5, last
//
// An event is held in the event register, then its reports are written
// into a three-entry report buffer that drains one report a cycle while
// rpt_o.ready is high. Ordinary events: one report. Caps-lock tap: three
// reports. A new set can load while the last pending report of the old leaves.
// Reset clears modifiers, key slots and hold count at once; no sweep.
// A stalled report output holds the buffer; the event register keeps one
// event waiting and evt_i.ready drops until the buffer can take its set.

module hid_boot_report_key_tracker #(
  parameter int unsigned KEY_SLOTS = hbkt_pkg::KEY_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hbkt_event_if.sink    evt_i,
  hbkt_report_if.source rpt_o
);

  hbkt_pkg::event_t          ev_q;
  logic                      ev_vld_q, ev_vld_d;
  logic                      load;
  logic                      ev_take;
  hbkt_pkg::buf_stat_t       stat;
  hbkt_pkg::rpt_set_t        set;

  logic [7:0]                mods_q, mods_d;
  logic [KEY_SLOTS-1:0][7:0] slots_q, slots_d;
  logic [7:0]                hold_q, hold_d;

  // Event register handshake
  assign load        = ev_vld_q && stat.can_load;
  assign evt_i.ready = !ev_vld_q || load;
  assign ev_take     = evt_i.valid && evt_i.ready;
  assign ev_vld_d    = ev_take || (ev_vld_q && !load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
    end else begin
      ev_vld_q <= ev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take) begin
      ev_q.pressed   <= evt_i.pressed;
      ev_q.keycode   <= evt_i.keycode;
      ev_q.caps_pair <= evt_i.caps_pair;
    end
  end

  // Report state and key table update
  hbkt_update #(
    .KeySlots (KEY_SLOTS)
  ) u_update (
    .ev_i    (ev_q),
    .mods_i  (mods_q),
    .slots_i (slots_q),
    .hold_i  (hold_q),
    .mods_o  (mods_d),
    .slots_o (slots_d),
    .hold_o  (hold_d),
    .set_o   (set)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q  <= 8'd0;
      slots_q <= '0;
      hold_q  <= 8'd0;
    end else if (load) begin
      mods_q  <= mods_d;
      slots_q <= slots_d;
      hold_q  <= hold_d;
    end
  end

  // Report buffer
  hbkt_report_buf u_report_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .set_i  (set),
    .stat_o (stat),
    .rpt_o  (rpt_o)
  );

`ifndef NO_ASSERTIONS
  // A loaded set always shows a report next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> rpt_o.valid)
    else $error("report set loaded but no report valid");

  // A blocked event stays in the event register
  a_event_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_vld_q && !load) |=> (ev_vld_q && $stable(ev_q)))
    else $error("waiting event lost");

  // Hold count moves by at most one per event
  a_hold_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hold_q == $past(hold_q) || hold_q == $past(hold_q) + 8'd1 ||
              hold_q == $past(hold_q) - 8'd1))
    else $error("hold count jumped");

  // Loads only into a buffer that is empty or draining
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!stat.busy || (rpt_o.valid && rpt_o.ready)))
    else $error("report set overwrote pending reports");
`endif

endmodule

`default_nettype wire
